// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent checks clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define SW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("swish check failed");

// consequent must hold in the cycle after the antecedent
`define SW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swish check failed");

`endif

// ===== hdl/swish_pkg.sv =====
// ----------------------------------------------------------------------------
// swish_pkg
// constants, sideband type and helpers of the fp32 swish pipeline
// ----------------------------------------------------------------------------
package swish_pkg;

  // fp32 constants
  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE  = 32'hBF80_0000;
  localparam logic [31:0] FP_TWO      = 32'h4000_0000;
  localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] FP_LN2R     = 32'h3FB8_AA3B;  // 1.442695
  localparam logic [31:0] FP_POLY_A   = 32'h3F56_594B;  // 0.8373
  localparam logic [31:0] FP_POLY_B   = 32'h3F5D_0000;  // 0.86328125
  localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;

  localparam logic [7:0] EXP_BIAS  = 8'd127;
  localparam logic [7:0] EXP_HALF  = 8'd126;
  localparam int         SQ_COUNT  = 8;

  // fused multiply-add units along the chain
  localparam int IDX_POLY_T   = 0;
  localparam int IDX_POLY_P   = 1;
  localparam int IDX_SQ       = 2;
  localparam int IDX_RCP1     = IDX_SQ + SQ_COUNT;
  localparam int IDX_ONE_PLUS = IDX_RCP1 + 6;
  localparam int IDX_RCP2     = IDX_ONE_PLUS + 1;
  localparam int IDX_MIRROR   = IDX_RCP2 + 6;
  localparam int IDX_PROD     = IDX_MIRROR + 1;
  localparam int FMA_COUNT    = IDX_PROD + 1;
  localparam int FMA_LAT      = 4;

  // values carried alongside each item
  typedef struct packed {
    logic [31:0] x_bits;
    logic [31:0] aux;
    logic [31:0] w;
    logic [7:0]  v_exp;
  } side_t;

  // exponent re-bias and underflow flush at the end of a reciprocal
  function automatic logic [31:0] rcp_finish(input logic [31:0] r, input logic [7:0] v_exp);
    logic signed [10:0] n;
    logic [31:0]        res;
    n = $signed({3'd0, r[30:23]}) - $signed({3'd0, v_exp}) + 11'sd126;
    if (n < 11'sd0) begin
      res = 32'd0;
    end else begin
      res = {r[31], n[7:0], r[22:0]};
    end
    return res;
  endfunction

endpackage

// ===== hdl/swish_fma.sv =====
// ----------------------------------------------------------------------------
// swish_fma
// four-stage fp32 fused multiply-add, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module swish_fma (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [31:0]       c_i,
  input  swish_pkg::side_t  side_i,
  output logic              valid_o,
  output logic [31:0]       res_o,
  output swish_pkg::side_t  side_o
);
  import swish_pkg::*;

  // ---------------- stage 1: unpack, multiply, align addend
  logic [7:0]         ea_f, eb_f, ec_f, ea, eb, ecv;
  logic               a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
  logic               sp, sc, is_nan, is_inf, is_spec;
  logic [23:0]        ma, mb, mc;
  logic signed [10:0] pe, ec, sh, nsh, base;
  logic [6:0]         ash, psh;
  logic [77:0]        a_win, a_shift;
  logic               a_lost;
  logic [31:0]        spec_res;

  always_comb begin
    ea_f   = a_i[30:23];
    eb_f   = b_i[30:23];
    ec_f   = c_i[30:23];
    a_zero = (ea_f == 8'd0) && (a_i[22:0] == 23'd0);
    b_zero = (eb_f == 8'd0) && (b_i[22:0] == 23'd0);
    c_zero = (ec_f == 8'd0) && (c_i[22:0] == 23'd0);
    a_inf  = (ea_f == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (eb_f == 8'hFF) && (b_i[22:0] == 23'd0);
    c_inf  = (ec_f == 8'hFF) && (c_i[22:0] == 23'd0);
    a_nan  = (ea_f == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (eb_f == 8'hFF) && (b_i[22:0] != 23'd0);
    c_nan  = (ec_f == 8'hFF) && (c_i[22:0] != 23'd0);
    sp     = a_i[31] ^ b_i[31];
    sc     = c_i[31];

    is_nan = a_nan | b_nan | c_nan | (a_inf & b_zero) | (b_inf & a_zero)
           | ((a_inf | b_inf) & c_inf & (sp != sc));
    is_inf = a_inf | b_inf | c_inf;
    is_spec = is_nan | is_inf | a_zero | b_zero;
    if (is_nan) begin
      spec_res = FP_QNAN;
    end else if (is_inf) begin
      spec_res = {((a_inf | b_inf) ? sp : sc), 8'hFF, 23'd0};
    end else if (c_zero) begin
      spec_res = {sp & sc, 31'd0};
    end else begin
      spec_res = c_i;
    end

    ma  = {ea_f != 8'd0, a_i[22:0]};
    mb  = {eb_f != 8'd0, b_i[22:0]};
    mc  = {ec_f != 8'd0, c_i[22:0]};
    ea  = (ea_f == 8'd0) ? 8'd1 : ea_f;
    eb  = (eb_f == 8'd0) ? 8'd1 : eb_f;
    ecv = (ec_f == 8'd0) ? 8'd1 : ec_f;
    pe  = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd127;
    ec  = $signed({3'd0, ecv});
    sh  = pe - ec + 11'sd27;
    nsh = -sh;

    // addend sits above the product; whichever side is far smaller is jammed
    if (sh < 11'sd0) begin
      ash  = 7'd0;
      psh  = (nsh > 11'sd78) ? 7'd78 : nsh[6:0];
      base = ec - 11'sd27;
    end else begin
      ash  = (sh > 11'sd78) ? 7'd78 : sh[6:0];
      psh  = 7'd0;
      base = pe;
    end
    a_win   = {1'b0, mc, 53'd0};
    a_shift = a_win >> ash;
    a_lost  = (a_shift << ash) != a_win;
  end

  logic               s1_valid_q;
  logic [47:0]        s1_prod_q;
  logic [77:0]        s1_add_q;
  logic [6:0]         s1_psh_q;
  logic signed [10:0] s1_base_q;
  logic               s1_sp_q, s1_sc_q, s1_spec_q;
  logic [31:0]        s1_spec_res_q;
  side_t              s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_prod_q     <= ma * mb;
      s1_add_q      <= a_shift | {77'd0, a_lost};
      s1_psh_q      <= psh;
      s1_base_q     <= base;
      s1_sp_q       <= sp;
      s1_sc_q       <= sc;
      s1_spec_q     <= is_spec;
      s1_spec_res_q <= spec_res;
      s1_side_q     <= side_i;
    end
  end

  // ---------------- stage 2: align product, add or subtract magnitudes
  logic [77:0] p_win, p_shift, p_al, sum_ab, dif_ap, dif_pa, mag;
  logic        p_lost, a_ge, eff_sub, mag_sign;

  always_comb begin
    p_win   = {27'd0, s1_prod_q, 3'd0};
    p_shift = p_win >> s1_psh_q;
    p_lost  = (p_shift << s1_psh_q) != p_win;
    p_al    = p_shift | {77'd0, p_lost};
    sum_ab  = s1_add_q + p_al;
    dif_ap  = s1_add_q - p_al;
    dif_pa  = p_al - s1_add_q;
    a_ge    = s1_add_q >= p_al;
    eff_sub = s1_sp_q ^ s1_sc_q;
    if (!eff_sub) begin
      mag      = sum_ab;
      mag_sign = s1_sp_q;
    end else if (a_ge) begin
      mag      = dif_ap;
      mag_sign = s1_sc_q;
    end else begin
      mag      = dif_pa;
      mag_sign = s1_sp_q;
    end
    // exact cancellation rounds to +0
    if (mag == 78'd0) begin
      mag_sign = 1'b0;
    end
  end

  logic               s2_valid_q;
  logic [77:0]        s2_sum_q;
  logic               s2_sign_q, s2_spec_q;
  logic signed [10:0] s2_base_q;
  logic [31:0]        s2_spec_res_q;
  side_t              s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sum_q      <= mag;
      s2_sign_q     <= mag_sign;
      s2_base_q     <= s1_base_q;
      s2_spec_q     <= s1_spec_q;
      s2_spec_res_q <= s1_spec_res_q;
      s2_side_q     <= s1_side_q;
    end
  end

  // ---------------- stage 3: normalize, clamped at the subnormal boundary
  logic [6:0]         lz, lsh, rsh;
  logic signed [10:0] lmax, nlmax, e_norm;
  logic [77:0]        t_norm;
  logic               r_lost;

  always_comb begin
    lz = 7'd78;
    for (int i = 0; i < 78; i++) begin
      if (s2_sum_q[i]) begin
        lz = 7'(77 - i);
      end
    end
    lmax   = s2_base_q + 11'sd27;
    nlmax  = -lmax;
    lsh    = 7'd0;
    rsh    = 7'd0;
    r_lost = 1'b0;
    if (lmax < 11'sd0) begin
      rsh    = (nlmax > 11'sd78) ? 7'd78 : nlmax[6:0];
      t_norm = s2_sum_q >> rsh;
      r_lost = (t_norm << rsh) != s2_sum_q;
    end else begin
      lsh    = ($signed({4'd0, lz}) < lmax) ? lz : lmax[6:0];
      t_norm = s2_sum_q << lsh;
    end
    e_norm = t_norm[77] ? (s2_base_q + 11'sd28 - $signed({4'd0, lsh})) : 11'sd0;
  end

  logic               s3_valid_q;
  logic [77:0]        s3_t_q;
  logic               s3_lost_q, s3_sign_q, s3_spec_q;
  logic signed [10:0] s3_exp_q;
  logic [31:0]        s3_spec_res_q;
  side_t              s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_t_q        <= t_norm;
      s3_lost_q     <= r_lost;
      s3_exp_q      <= e_norm;
      s3_sign_q     <= s2_sign_q;
      s3_spec_q     <= s2_spec_q;
      s3_spec_res_q <= s2_spec_res_q;
      s3_side_q     <= s2_side_q;
    end
  end

  // ---------------- stage 4: round to nearest even and pack
  logic        g_bit, st_bit, rnd_up;
  logic [30:0] packed_mag;
  logic [31:0] fin_res;

  always_comb begin
    g_bit      = s3_t_q[53];
    st_bit     = (s3_t_q[52:0] != 53'd0) | s3_lost_q;
    rnd_up     = g_bit & (st_bit | s3_t_q[54]);
    packed_mag = {s3_exp_q[7:0], s3_t_q[76:54]} + {30'd0, rnd_up};
    if (s3_spec_q) begin
      fin_res = s3_spec_res_q;
    end else if (s3_exp_q > 11'sd254) begin
      fin_res = {s3_sign_q, 8'hFF, 23'd0};
    end else begin
      fin_res = {s3_sign_q, packed_mag};
    end
  end

  logic        s4_valid_q;
  logic [31:0] s4_res_q;
  side_t       s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_res_q  <= fin_res;
      s4_side_q <= s3_side_q;
    end
  end

  assign valid_o = s4_valid_q;
  assign res_o   = s4_res_q;
  assign side_o  = s4_side_q;

endmodule

// ===== hdl/swish_activation_fp32.sv =====
// ----------------------------------------------------------------------------
// swish_activation_fp32
// streaming fp32 swish y = x * sigmoid(x), when unstalled one value per cycle
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one fp32 bit pattern x per transfer, m_axis returns the
//   fp32 bit pattern of x * sigmoid(x). items are independent and keep order.
//   throughput: one transfer per cycle in and out while the receiver keeps
//   m_axis_tready high. an input transfer reaches m_axis_tvalid through a
//   chain of 25 fused multiply-add units of 4 register stages each plus
//   one output register.
//   the whole chain advances on one enable; it holds only when the output
//   register is full, not taken, and the last stage has a result waiting.
//   while the output register waits, inputs flow until the last stage fills.
//   reset clears every valid bit; payload registers keep stale data that
//   is never presented. no result ever appears without a matching input.
//   a receiver stall never drops or repeats a result.
//   nan results come out as the quiet nan 0x7fc00000.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swish_activation_fp32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] y_bits
);
  import swish_pkg::*;

  // chain wiring between the multiply-add units
  logic        vin  [FMA_COUNT];
  logic        vout [FMA_COUNT];
  logic [31:0] op_a [FMA_COUNT];
  logic [31:0] op_b [FMA_COUNT];
  logic [31:0] op_c [FMA_COUNT];
  logic [31:0] res  [FMA_COUNT];
  side_t       sd_in  [FMA_COUNT];
  side_t       sd_out [FMA_COUNT];

  logic        pipe_en;
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        out_load;

  // output register frees up when empty or taken; chain runs unless the
  // last stage holds a result that has nowhere to go
  assign out_load      = !out_valid_q || m_axis_tready;
  assign pipe_en       = !vout[FMA_COUNT-1] || out_load;
  assign s_axis_tready = pipe_en;

  for (genvar gi = 0; gi < FMA_COUNT; gi++) begin : g_fma
    swish_fma u_fma (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (vin[gi]),
      .a_i     (op_a[gi]),
      .b_i     (op_b[gi]),
      .c_i     (op_c[gi]),
      .side_i  (sd_in[gi]),
      .valid_o (vout[gi]),
      .res_o   (res[gi]),
      .side_o  (sd_out[gi])
    );
  end

  logic [31:0] a_red, e_val, s_val, w_val;
  logic        x_neg;
  int          rb;

  always_comb begin
    // default: valid and sideband just follow the chain
    for (int i = 1; i < FMA_COUNT; i++) begin
      vin[i]   = vout[i-1];
      sd_in[i] = sd_out[i-1];
    end
    vin[0] = s_axis_tvalid;

    // |x| with the exponent pulled into [0.5,1) once |x| >= 1
    if (s_axis_tdata[30:23] >= EXP_BIAS) begin
      a_red = {1'b0, EXP_HALF, s_axis_tdata[22:0]};
    end else begin
      a_red = {1'b0, s_axis_tdata[30:0]};
    end
    sd_in[0].x_bits = s_axis_tdata;
    sd_in[0].aux    = a_red;
    sd_in[0].w      = 32'd0;
    sd_in[0].v_exp  = 8'd0;

    // quadratic in horner form
    op_a[IDX_POLY_T] = a_red;
    op_b[IDX_POLY_T] = FP_POLY_A;
    op_c[IDX_POLY_T] = FP_POLY_B;
    op_a[IDX_POLY_P] = sd_out[IDX_POLY_T].aux;
    op_b[IDX_POLY_P] = res[IDX_POLY_T];
    op_c[IDX_POLY_P] = FP_ONE;

    // predicated squarings, a skipped one multiplies by one
    for (int j = 0; j < SQ_COUNT; j++) begin
      op_a[IDX_SQ+j] = res[IDX_SQ+j-1];
      op_b[IDX_SQ+j] = (sd_out[IDX_SQ+j-1].x_bits[30:23] >= 8'(EXP_BIAS + j)) ?
                       res[IDX_SQ+j-1] : FP_ONE;
      op_c[IDX_SQ+j] = FP_NEG_ZERO;
    end

    // two reciprocals: seed then two newton steps
    for (int k = 0; k < 2; k++) begin
      rb    = (k == 0) ? IDX_RCP1 : IDX_RCP2;
      w_val = {1'b1, EXP_HALF, res[rb-1][22:0]};
      sd_in[rb].w     = w_val;
      sd_in[rb].v_exp = res[rb-1][30:23];
      op_a[rb]   = w_val;
      op_b[rb]   = FP_LN2R;
      op_c[rb]   = FP_TWO;
      op_a[rb+1] = FP_LN2R;
      op_b[rb+1] = res[rb];
      op_c[rb+1] = FP_NEG_ZERO;
      op_a[rb+2] = sd_out[rb+1].w;
      op_b[rb+2] = res[rb+1];
      op_c[rb+2] = FP_TWO;
      sd_in[rb+2].aux = res[rb+1];
      op_a[rb+3] = sd_out[rb+2].aux;
      op_b[rb+3] = res[rb+2];
      op_c[rb+3] = FP_NEG_ZERO;
      op_a[rb+4] = sd_out[rb+3].w;
      op_b[rb+4] = res[rb+3];
      op_c[rb+4] = FP_TWO;
      sd_in[rb+4].aux = res[rb+3];
      op_a[rb+5] = sd_out[rb+4].aux;
      op_b[rb+5] = res[rb+4];
      op_c[rb+5] = FP_NEG_ZERO;
    end

    // 1 + e^-|x|
    e_val = rcp_finish(res[IDX_RCP1+5], sd_out[IDX_RCP1+5].v_exp);
    op_a[IDX_ONE_PLUS] = e_val;
    op_b[IDX_ONE_PLUS] = FP_ONE;
    op_c[IDX_ONE_PLUS] = FP_ONE;

    // sigmoid, mirrored to 1 - s for negative nonzero x
    s_val = rcp_finish(res[IDX_RCP2+5], sd_out[IDX_RCP2+5].v_exp);
    x_neg = sd_out[IDX_RCP2+5].x_bits[31] && (sd_out[IDX_RCP2+5].x_bits[30:0] != 31'd0);
    op_a[IDX_MIRROR] = s_val;
    op_b[IDX_MIRROR] = x_neg ? FP_NEG_ONE : FP_ONE;
    op_c[IDX_MIRROR] = x_neg ? FP_ONE : FP_NEG_ZERO;

    // final product x * s
    op_a[IDX_PROD] = sd_out[IDX_MIRROR].x_bits;
    op_b[IDX_PROD] = res[IDX_MIRROR];
    op_c[IDX_PROD] = FP_NEG_ZERO;
  end

  // output register between the chain and the receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= vout[FMA_COUNT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res[FMA_COUNT-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a nan result always carries the quiet nan pattern
  `SW_ASSERT(a_canon_nan, !(out_valid_q && (out_data_q[30:23] == 8'hFF) && (out_data_q[22:0] != 23'd0)) || (out_data_q == FP_QNAN))
  // with the output register empty the input side must be open
  `SW_ASSERT(a_ready_when_free, !out_valid_q |-> s_axis_tready)
  // the chain only stops for a full, untaken output register
  `SW_ASSERT(a_stall_cause, !pipe_en |-> (out_valid_q && !m_axis_tready && vout[FMA_COUNT-1]))
  // a stopped chain keeps its last result in place
  `SW_ASSERT_NEXT(a_last_held, !pipe_en, $stable(res[FMA_COUNT-1]) && vout[FMA_COUNT-1])

endmodule

// ===== tb/swish_activation_fp32_test.sv =====
// ----------------------------------------------------------------------------
// swish_activation_fp32_test
// streams fp32 values through the swish pipeline and checks every result
// bit for bit against an in-bench predictor of the e^-|x| / reciprocal
// chain, under random bursts on the input and random stalls on the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swish_activation_fp32_test;
  import swish_pkg::*;

  localparam logic [31:0] EXP_FIELD  = 32'h7F80_0000;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] POS_INF    = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF    = 32'hFF80_0000;
  localparam real         OVF_EDGE   = 3.40282356779733661637539395458142568448e38;
  localparam int          N_RANDOM   = 1630;
  localparam int          DRAIN_AT   = 700;
  localparam int          TAIL_WAIT  = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] x_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] y_bits

  logic [31:0] pending_x_q[$];   // values not yet put on the bus
  logic [31:0] swish_exp_q[$];   // predicted y bits, oldest first
  int          n_accepted;
  int          n_checked;
  int          n_errors;
  int          burst_left;
  int          gap_left;
  bit          drain_hold;
  bit          drain_done;
  int          cyc;

  swish_activation_fp32 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------- fp32 math
  // fp32 bits to a double, exact
  function automatic real sp_to_real(input logic [31:0] f);
    real m;
    if (f[30:23] == 8'hFF) begin
      return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
    end
    if (f[30:23] == 8'h00) begin
      if (f[22:0] == 23'd0) return $bitstoreal({f[31], 63'd0});
      m = real'(f[22:0]) * (2.0 ** (-149));
      return f[31] ? -m : m;
    end
    return $bitstoreal({f[31], {3'd0, f[30:23]} + 11'd896, f[22:0], 29'd0});
  endfunction

  // double to fp32, round to nearest even, subnormals kept
  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0] b;
    logic [63:0] sig, q, rem, half;
    logic        sg;
    int          e, sh;
    b  = $realtobits(r);
    sg = b[63];
    e  = int'(b[62:52]);
    if (e == 2047) return {sg, 8'hFF, b[51:0] != 52'd0, 22'd0};
    if (e == 0) return {sg, 31'd0};
    sig = {11'd0, 1'b1, b[51:0]};
    e   = e - 1023;
    sh  = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) sh = 60;
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (e >= -126) begin
      if (q[24]) begin
        q = q >> 1;
        e = e + 1;
      end
      if (e + 127 >= 255) return {sg, 8'hFF, 23'd0};
      return {sg, 8'(e + 127), q[22:0]};
    end
    // a rounded-up subnormal lands on the smallest normal by itself
    return {sg, q[30:0]};
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  // a*b+c rounded once: exact product, round-to-odd sum in double, then to fp32
  function automatic logic [31:0] sp_fma(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    real         p, cc, sm, bb, err;
    logic [63:0] sb;
    p  = sp_to_real(a) * sp_to_real(b);
    cc = sp_to_real(c);
    sm = p + cc;
    if (sm - sm == 0.0) begin
      bb  = sm - p;
      err = (p - (sm - bb)) + (cc - bb);
      if (err != 0.0) begin
        sb = $realtobits(sm);
        if (!sb[0]) begin
          if ((err > 0.0) == (sm > 0.0)) sb = sb + 64'd1;
          else sb = sb - 64'd1;
          sm = $bitstoreal(sb);
        end
      end
      if (sm >= OVF_EDGE) return POS_INF;
      if (sm <= -OVF_EDGE) return NEG_INF;
    end
    return real_to_sp(sm);
  endfunction

  function automatic int unbiased_exp(input logic [31:0] f);
    return int'(f[30:23]) - 127;
  endfunction

  // seeded newton reciprocal of the mantissa, then exponent re-bias with flush
  function automatic logic [31:0] newton_recip(input logic [31:0] v);
    logic [31:0] w, r;
    int          n;
    w = ((v | SIGN_BIT) & ~EXP_FIELD) | {1'b0, EXP_HALF, 23'd0};
    r = sp_mul(FP_LN2R, sp_fma(w, FP_LN2R, FP_TWO));
    for (int i = 0; i < 2; i++) r = sp_mul(r, sp_fma(w, r, FP_TWO));
    n = unbiased_exp(r) - unbiased_exp(v) + 126;
    if (n < 0) begin
      r = 32'd0;
      n = 0;
    end
    return (r & ~EXP_FIELD) | {1'b0, n[7:0], 23'd0};
  endfunction

  // e^-|x|: range fold, quadratic, up to eight squarings, reciprocal
  function automatic logic [31:0] exp_neg_mag(input logic [31:0] mag);
    logic [31:0] a, t;
    int          k;
    a = mag;
    k = unbiased_exp(mag);
    if (k >= 0) a = (a & ~EXP_FIELD) | {1'b0, EXP_HALF, 23'd0};
    t = sp_fma(a, FP_POLY_A, FP_POLY_B);
    a = sp_fma(a, t, FP_ONE);
    if (k >= 0) begin
      a = sp_mul(a, a);
      for (int i = 0; i < SQ_COUNT - 1; i++) begin
        k = k - 1;
        if (k >= 0) a = sp_mul(a, a);
      end
    end
    return newton_recip(a);
  endfunction

  function automatic logic [31:0] swish_predict(input logic [31:0] x);
    logic [31:0] mag, en, sg, y;
    mag = x & ~SIGN_BIT;
    en  = exp_neg_mag(mag);
    sg  = newton_recip(sp_fma(FP_ONE, FP_ONE, en));
    if (x[31] && mag != 32'd0) sg = sp_fma(sg, FP_NEG_ONE, FP_ONE);
    y = sp_mul(x, sg);
    if (y[30:23] == 8'hFF && y[22:0] != 23'd0) y = FP_QNAN;
    return y;
  endfunction

  // mostly values where the curve bends, plus raw patterns and the extremes
  function automatic logic [31:0] random_x();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1:    ;
      2, 3, 4: v[30:23] = 8'($urandom_range(118, 131));
      5, 6:    v[30:23] = 8'($urandom_range(100, 134));
      7:       v[30:23] = 8'($urandom_range(0, 2));
      8:       v[30:23] = 8'($urandom_range(250, 255));
      default: v[30:23] = 8'($urandom_range(132, 200));
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------- driver
  // one nonblocking write per signal per edge; bursts and gaps chosen here
  always @(posedge clk_i or negedge rst_ni) begin
    bit          bus_free;
    bit          nxt_valid;
    logic [31:0] nxt_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 32'd0;
      burst_left    <= 0;
      gap_left      <= 0;
      drain_hold    <= 1'b0;
      drain_done    <= 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      bus_free  = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        swish_exp_q.push_back(swish_predict(s_axis_tdata));
        n_accepted = n_accepted + 1;
        bus_free   = 1'b1;
        nxt_valid  = 1'b0;
        // pressure point: stop feeding once until the pipe has fully drained
        if (n_accepted == DRAIN_AT && !drain_done) drain_hold <= 1'b1;
      end
      if (drain_hold && swish_exp_q.size() == 0) begin
        drain_hold <= 1'b0;
        drain_done <= 1'b1;
      end
      if (bus_free) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (!(drain_hold || (n_accepted == DRAIN_AT && !drain_done))
                     && pending_x_q.size() > 0) begin
          nxt_data  = pending_x_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
    end
  end

  // ---------------------------------------------------------------- monitor
  // compare each result transfer with the oldest prediction, then pick the
  // next ready from one of four stall modes selected by the cycle counter
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    int          mode;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      cyc           <= 0;
    end else begin
      cyc <= cyc + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (swish_exp_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %08h", $time, m_axis_tdata);
          n_errors = n_errors + 1;
        end else begin
          want = swish_exp_q.pop_front();
          n_checked = n_checked + 1;
          if (m_axis_tdata !== want) begin
            $display("%0t: y_bits mismatch, expected %08h actual %08h",
                     $time, want, m_axis_tdata);
            n_errors = n_errors + 1;
          end
        end
      end
      mode = (cyc / 256) % 4;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
        2:       m_axis_tready <= ((cyc % 7) < 3);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    n_accepted = 0;
    n_checked  = 0;
    n_errors   = 0;
    rst_ni     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 32'd0;
    m_axis_tready = 1'b0;

    // zeros, ones, infinities, nans, subnormal and normal extremes, and the
    // edges where the squaring count saturates or the result flushes
    pending_x_q.push_back(32'h0000_0000);
    pending_x_q.push_back(FP_NEG_ZERO);
    pending_x_q.push_back(FP_ONE);
    pending_x_q.push_back(FP_NEG_ONE);
    pending_x_q.push_back(POS_INF);
    pending_x_q.push_back(NEG_INF);
    pending_x_q.push_back(FP_QNAN);
    pending_x_q.push_back(32'hFFFF_FFFF);
    pending_x_q.push_back(32'h7F80_0001);
    pending_x_q.push_back(32'h7F7F_FFFF);
    pending_x_q.push_back(32'hFF7F_FFFF);
    pending_x_q.push_back(32'h0000_0001);
    pending_x_q.push_back(32'h8000_0001);
    pending_x_q.push_back(32'h007F_FFFF);
    pending_x_q.push_back(32'h0080_0000);
    pending_x_q.push_back(32'h3F7F_FFFF);
    pending_x_q.push_back(32'hBF7F_FFFF);
    pending_x_q.push_back(32'h4300_0000);
    pending_x_q.push_back(32'hC300_0000);
    pending_x_q.push_back(32'h42C8_0000);
    pending_x_q.push_back(32'hC2C8_0000);
    pending_x_q.push_back(32'h4120_0000);
    pending_x_q.push_back(32'hC120_0000);
    pending_x_q.push_back(32'hBE80_0000);
    pending_x_q.push_back(32'h5555_5555);
    for (int i = 0; i < N_RANDOM; i++) pending_x_q.push_back(random_x());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_x_q.size() != 0 || s_axis_tvalid || swish_exp_q.size() != 0)
      @(posedge clk_i);
    // anything arriving now would be a result without an input
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("covered %0d values: signed extremes, non-finite, subnormal, saturation",
             n_accepted);
    $display("and %0d checked results under bursts, stalls and one full drain", n_checked);
    if (n_errors == 0 && swish_exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", swish_exp_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== swish_activation_fp32.f =====
+incdir+hdl
hdl/swish_pkg.sv
hdl/swish_fma.sv
hdl/swish_activation_fp32.sv
tb/swish_activation_fp32_test.sv
